[design/circular_fifo_queue_unit_assert.svh]
// ----------------------------------------------------------------------------
// circular_fifo_queue_unit assertion macros
// concurrent assertion helpers clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_UNIT_ASSERT_SVH
`define CIRCULAR_FIFO_QUEUE_UNIT_ASSERT_SVH

// invariant that holds at every clock edge out of reset
`define CFQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define CFQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[design/cfq_pkg.sv]
// ----------------------------------------------------------------------------
// cfq_pkg
// shared types and constants of the circular fifo queue unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfq_pkg;

    // default queue depth in words
    localparam int unsigned DEPTH_DEFAULT = 16;

    // field widths
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 5;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 40;

    // request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2
    } opcode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

[design/cfq_ram.sv]
// ----------------------------------------------------------------------------
// cfq_ram
// generic single-clock ram, one write port and one read port, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/circular_fifo_queue_unit.sv]
// ----------------------------------------------------------------------------
// circular_fifo_queue_unit
// circular fifo of signed 32-bit words driven by an opcode request stream
// ----------------------------------------------------------------------------
// usage
//   the s_ channel carries requests: enqueue, dequeue or peek at head.
//   the m_ channel returns exactly one result per request, in order:
//   status, head word (dequeue/peek hits only, else zero), occupancy after
//   the request and an empty flag.
//   a request passes through the middle stage and then the output register,
//   which drives m_tvalid. the head/count update and the slot ram access
//   happen at the request edge; the ram's registered read is loaded into
//   the output register when the result leaves the middle stage.
//   one request per cycle while the receiver does not stall; the slot ram
//   sees at most one access per request, so a write and a read never collide.
//   reset (aresetn low, synchronous) empties the queue: head and count go
//   to zero and both the middle stage and the output register drop valid.
//   s_tready stays low while aresetn is low.
//   slot contents are not cleared; only written slots are ever read.
//   when the receiver stalls, the result holds in the output register, one
//   more request sits in the middle stage, then s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_fifo_queue_unit #(
    parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode [1:0], data_in [33:2], zero pad [39:34]
    input  logic [cfq_pkg::S_TDATA_W-1:0]  s_tdata,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [1:0], data_out [33:2], occupancy [38:34], is_empty [39]
    output logic [cfq_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    // queue state
    logic [AW-1:0]             head_reg, head_next;
    logic [CW-1:0]             count_reg, count_next;

    // middle stage: result waiting on the ram read
    logic                      p_valid_reg, p_valid_next;
    logic                      p_read_reg, p_read_next;
    cfq_pkg::status_t          p_status_reg, p_status_next;
    logic [cfq_pkg::OCC_W-1:0] p_occ_reg, p_occ_next;
    logic                      p_empty_reg, p_empty_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    cfq_pkg::status_t          out_status_reg, out_status_next;
    logic [cfq_pkg::WORD_W-1:0] out_data_reg, out_data_next;
    logic [cfq_pkg::OCC_W-1:0] out_occ_reg, out_occ_next;
    logic                      out_empty_reg, out_empty_next;

    // handshake and ram control
    logic                      s_accept;
    logic                      out_free;
    logic                      p_move;
    logic                      p_stall;
    cfq_pkg::opcode_t          req_op;
    logic [cfq_pkg::WORD_W-1:0] req_word;
    logic [SW-1:0]             tail_sum;
    logic [AW-1:0]             tail_idx;
    logic                      is_full;
    logic                      is_void;
    logic                      ram_wr_en;
    logic                      ram_rd_en;
    logic [cfq_pkg::WORD_W-1:0] ram_rd_data;

    // request fields
    assign req_op   = cfq_pkg::opcode_t'(s_tdata[cfq_pkg::OPCODE_W-1:0]);
    assign req_word = s_tdata[cfq_pkg::OPCODE_W +: cfq_pkg::WORD_W];

    // pipeline flow
    assign out_free = !out_valid_reg || m_tready;
    assign p_move   = p_valid_reg && out_free;
    assign p_stall  = p_valid_reg && p_read_reg && !out_free;
    assign s_tready = aresetn && (!p_valid_reg || out_free);
    assign s_accept = s_tvalid && s_tready;

    // tail slot: head plus count, wrapped with one compare and subtract
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                               : AW'(tail_sum);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_void  = (count_reg == '0);

    // request decode, queue update and middle stage load
    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        p_valid_next  = p_valid_reg;
        p_read_next   = p_read_reg;
        p_status_next = p_status_reg;
        p_occ_next    = p_occ_reg;
        p_empty_next  = p_empty_reg;

        if (p_move) begin
            p_valid_next = 1'b0;
        end

        if (s_accept) begin
            p_valid_next  = 1'b1;
            p_read_next   = 1'b0;
            p_status_next = cfq_pkg::ST_OK;
            case (req_op)
                cfq_pkg::OP_ENQ: begin
                    if (is_full) begin
                        p_status_next = cfq_pkg::ST_FULL;
                    end else begin
                        ram_wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                cfq_pkg::OP_DEQ: begin
                    if (is_void) begin
                        p_status_next = cfq_pkg::ST_EMPTY;
                    end else begin
                        ram_rd_en   = 1'b1;
                        p_read_next = 1'b1;
                        count_next  = count_reg - 1'b1;
                        head_next   = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    end
                end
                cfq_pkg::OP_PEEK: begin
                    if (is_void) begin
                        p_status_next = cfq_pkg::ST_EMPTY;
                    end else begin
                        ram_rd_en   = 1'b1;
                        p_read_next = 1'b1;
                    end
                end
                default: begin
                    // unused opcode leaves the queue alone
                end
            endcase
            p_occ_next   = cfq_pkg::OCC_W'(count_next);
            p_empty_next = (count_next == '0);
        end
    end

    // output register load
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_occ_next    = out_occ_reg;
        out_empty_next  = out_empty_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (p_move) begin
            out_valid_next  = 1'b1;
            out_status_next = p_status_reg;
            out_data_next   = p_read_reg ? ram_rd_data : '0;
            out_occ_next    = p_occ_reg;
            out_empty_next  = p_empty_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        p_read_reg     <= p_read_next;
        p_status_reg   <= p_status_next;
        p_occ_reg      <= p_occ_next;
        p_empty_reg    <= p_empty_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_occ_reg    <= out_occ_next;
        out_empty_reg  <= out_empty_next;
    end

    // slot storage
    cfq_ram #(
        .WIDTH (cfq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_idx),
        .wr_data (req_word),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_empty_reg, out_occ_reg, out_data_reg, out_status_reg};

    // checks
    `include "circular_fifo_queue_unit_assert.svh"

    `CFQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "word count above depth")
    `CFQ_ASSERT_ALWAYS(a_head_bound, SW'(head_reg) < SW'(DEPTH), "head index out of range")
    `CFQ_ASSERT_ALWAYS(a_ram_one_access, !(ram_wr_en && ram_rd_en), "slot write and read")
    `CFQ_ASSERT_NEXT(a_enq_count, ram_wr_en, count_reg == $past(count_reg) + 1'b1, "no count step")
    `CFQ_ASSERT_NEXT(a_read_hold, p_stall, $stable(ram_rd_data), "head word lost during stall")

endmodule

[tb/tb_circular_fifo_queue_unit.sv]
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue_unit
// checks the circular fifo queue unit against a behavioral queue model: a
// directed part covers the empty and full rejects, the unused opcode and the
// word extremes, then biased random traffic fills and drains the queue over
// and over while both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circular_fifo_queue_unit;

    localparam int unsigned QUEUE_DEPTH  = cfq_pkg::DEPTH_DEFAULT;
    localparam int unsigned HEAD_W       = $clog2(QUEUE_DEPTH);
    localparam int          LIMIT_CYCLES = 100000;
    localparam int          SETTLE_CYCLES = 8;

    // opcode value outside the enum, the block returns ok and leaves the queue alone
    localparam logic [cfq_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // request transaction layout, lowest field last
    typedef struct packed {
        logic [cfq_pkg::S_TDATA_W-cfq_pkg::OPCODE_W-cfq_pkg::WORD_W-1:0] pad;
        logic [cfq_pkg::WORD_W-1:0]                                      word;
        logic [cfq_pkg::OPCODE_W-1:0]                                    opcode;
    } request_bits_t;

    // result transaction layout, lowest field last
    typedef struct packed {
        logic                         is_empty;
        logic [cfq_pkg::OCC_W-1:0]    occupancy;
        logic [cfq_pkg::WORD_W-1:0]   data_out;
        logic [cfq_pkg::STATUS_W-1:0] status;
    } result_bits_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [cfq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cfq_pkg::M_TDATA_W-1:0] m_tdata;

    // queue model state
    logic [cfq_pkg::WORD_W-1:0] model_slot [QUEUE_DEPTH];
    logic [HEAD_W-1:0]          model_head;
    logic [cfq_pkg::OCC_W-1:0]  model_count;

    result_bits_t expected_results [$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int error_count       = 0;
    int cycle_count       = 0;

    circular_fifo_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%08h expected 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    // apply one accepted request to the model and queue its result
    function automatic void predict_queue_result(input logic [cfq_pkg::OPCODE_W-1:0] opcode,
                                                 input logic [cfq_pkg::WORD_W-1:0] word);
        result_bits_t r;
        int unsigned  slot;
        r.status   = cfq_pkg::ST_OK;
        r.data_out = '0;
        case (opcode)
            cfq_pkg::OP_ENQ: begin
                if (model_count >= QUEUE_DEPTH) begin
                    r.status = cfq_pkg::ST_FULL;
                end else begin
                    slot = (int'(model_head) + int'(model_count)) % QUEUE_DEPTH;
                    model_slot[slot] = word;
                    model_count++;
                end
            end
            cfq_pkg::OP_DEQ, cfq_pkg::OP_PEEK: begin
                if (model_count == 0) begin
                    r.status = cfq_pkg::ST_EMPTY;
                end else begin
                    r.data_out = model_slot[model_head];
                    if (opcode == cfq_pkg::OP_DEQ) begin
                        model_head = HEAD_W'((int'(model_head) + 1) % QUEUE_DEPTH);
                        model_count--;
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = model_count;
        r.is_empty  = (model_count == 0);
        expected_results.push_back(r);
    endfunction

    // result checker
    always @(posedge aclk) begin
        result_bits_t got;
        result_bits_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(got), '0);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.data_out !== want.data_out)
                    report_mismatch("data_out", got.data_out, want.data_out);
                if (got.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
            end
        end
    end

    // send one request, with random idle cycles first, and hold it until accepted
    task automatic send_request(input logic [cfq_pkg::OPCODE_W-1:0] opcode,
                                input logic [cfq_pkg::WORD_W-1:0] word);
        request_bits_t req;
        req.pad    = '0;
        req.word   = word;
        req.opcode = opcode;
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        predict_queue_result(opcode, word);
    endtask

    // sender holds off until every result is back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [cfq_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // dequeue, peek and unused opcode on a fresh, empty queue
    task automatic test_empty_requests();
        send_request(cfq_pkg::OP_DEQ, 32'h1234_5678);
        send_request(cfq_pkg::OP_PEEK, 32'hffff_ffff);
        send_request(OP_UNUSED, 32'haaaa_aaaa);
    endtask

    // fill with extreme words, then overflow and poke the full queue
    task automatic test_fill_and_overflow();
        logic [cfq_pkg::WORD_W-1:0] fill_words [6];
        fill_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                       32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa};
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(cfq_pkg::OP_ENQ, (i < 6) ? fill_words[i] : random_word());
        send_request(cfq_pkg::OP_ENQ, 32'hdead_beef);
        send_request(OP_UNUSED, 32'h0000_0001);
    endtask

    // dequeue from full, then peek the new head
    task automatic test_dequeue_then_peek();
        send_request(cfq_pkg::OP_DEQ, 32'h0);
        send_request(cfq_pkg::OP_PEEK, 32'h0);
    endtask

    // bursts biased toward filling or draining so the queue swings end to end
    task automatic test_random_traffic(input int count);
        int                           enq_bias;
        logic [cfq_pkg::OPCODE_W-1:0] opcode;
        enq_bias = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 24 == 0) begin
                case ($urandom_range(2))
                    0:       enq_bias = 85;
                    1:       enq_bias = 15;
                    default: enq_bias = 50;
                endcase
            end
            if (i == count / 2)
                wait_results_drained();
            if ($urandom_range(99) < 3)
                opcode = OP_UNUSED;
            else if ($urandom_range(99) < enq_bias)
                opcode = cfq_pkg::OP_ENQ;
            else if ($urandom_range(3) == 0)
                opcode = cfq_pkg::OP_PEEK;
            else
                opcode = cfq_pkg::OP_DEQ;
            send_request(opcode, random_word());
        end
    endtask

    initial begin
        // model reset
        model_head  = '0;
        model_count = '0;
        foreach (model_slot[i]) model_slot[i] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles a little, receiver a lot
        sender_idle_pct   = 18;
        receiver_idle_pct = 58;
        test_empty_requests();
        test_fill_and_overflow();
        test_dequeue_then_peek();
        wait_results_drained();
        test_random_traffic(420);

        // sender idles a lot, receiver a little
        sender_idle_pct   = 58;
        receiver_idle_pct = 18;
        test_random_traffic(420);
        wait_results_drained();

        // no idling
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(410);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[circular_fifo_queue_unit.f]
+incdir+design
design/cfq_pkg.sv
design/cfq_ram.sv
design/circular_fifo_queue_unit.sv
tb/tb_circular_fifo_queue_unit.sv
